// ===== hw/rtl/jbp_pkg.sv =====
// Shared types and constants for the JPEG bit packer with byte stuffing.
package jbp_pkg;

  // Largest code word one append beat may carry; larger counts saturate.
  localparam int unsigned MaxWriteBits = 16;

  // Field widths of the beats.
  localparam int unsigned CountW   = 5;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned PendW    = 15;
  localparam int unsigned PendCntW = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 24;  // bit_count + bit_value, padded to bytes

  // Up to two data bytes, each possibly followed by a stuffing byte.
  localparam int unsigned MaxBytes = 4;

  localparam logic [ByteW-1:0] MarkerByte = 8'hFF;
  localparam logic [ByteW-1:0] StuffByte  = 8'h00;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_e;

  typedef logic [ByteW-1:0] byte_t;

endpackage

// ===== hw/rtl/jpeg_bit_packer_with_stuffing_top.sv =====
// Top level of the JPEG bit packer: code word packing, flush padding and 0xFF/0x00 stuffing.
//
// Packs variable-length code words, most significant bit first, into a byte stream.
// An append beat (tuser = 0) adds the low bit_count bits of bit_value (counts above 16
// saturate to 16) to a pending store of up to 15 bits; whenever 16 or more bits are
// pending, the oldest 16 leave as two bytes, high byte first. A flush beat (tuser = 1)
// sends the pending bits as one or two bytes with the last byte padded with ones and
// clears the store; an empty flush sends nothing. Every 0xFF byte is followed by a
// 0x00 stuffing byte. tlast marks the final byte caused by one input beat; a beat that
// causes no byte leaves no trace on the output. The packing and stuffing of a
// beat are done in the cycle it is accepted and land in a four-byte result buffer,
// which drains one byte per cycle while m_axis_tready_i is high. A new input beat
// is taken while the buffer is empty or in the same cycle as the last byte of the
// previous one leaves; an append whose two bytes are both 0xFF fills all four
// buffer bytes.
module jpeg_bit_packer_with_stuffing_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [jbp_pkg::InDataW-1:0] s_axis_tdata_i,  // [4:0] bit_count, [20:5] bit_value
  input  logic                      s_axis_tuser_i,   // [0] kind
  // Output stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [jbp_pkg::ByteW-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic                      m_axis_tlast_o    // last_of_run
);
  import jbp_pkg::*;

  // Pending bit store; bits above pend_cnt_q are always zero.
  logic [PendW-1:0]    pend_q, pend_d;
  logic [PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  // Result buffer: bytes of one input beat, drained in order.
  byte_t      buf_q [MaxBytes];
  byte_t      buf_d [MaxBytes];
  logic [2:0] left_q, left_d;   // bytes still to send, 0..4
  logic [1:0] rd_q, rd_d;       // index of the byte on the output

  logic in_beat, out_beat;

  // Input fields
  kind_e             kind;
  logic [CountW-1:0] bit_count;
  logic [ValueW-1:0] bit_value;

  assign kind      = kind_e'(s_axis_tuser_i);
  assign bit_count = s_axis_tdata_i[CountW-1:0];
  assign bit_value = s_axis_tdata_i[CountW+ValueW-1:CountW];

  assign m_axis_tvalid_o = (left_q != 3'd0);
  assign m_axis_tdata_o  = buf_q[rd_q];
  assign m_axis_tlast_o  = (left_q == 3'd1);
  assign out_beat        = m_axis_tvalid_o & m_axis_tready_i;

  // Take a new beat once the buffer is empty or its last byte leaves now.
  assign s_axis_tready_o = (left_q == 3'd0) || ((left_q == 3'd1) && m_axis_tready_i);
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;

  // Packing datapath
  logic [CountW-1:0] n_sat;
  logic [31:0]       acc;
  logic [CountW-1:0] total;
  logic [CountW-1:0] excess;
  logic [31:0]       word_sh;
  logic [31:0]       flush_al;
  logic [CountW-1:0] fl_shift;
  byte_t             raw [2];
  logic [1:0]        raw_cnt;
  logic [PendW-1:0]  app_pend;
  logic [PendCntW-1:0] app_cnt;

  always_comb begin
    n_sat = (bit_count > CountW'(MaxWriteBits)) ? CountW'(MaxWriteBits) : bit_count;
    // Shift the store left and append the masked code bits.
    acc = ({17'd0, pend_q} << n_sat)
        | ({16'd0, bit_value} & ((32'd1 << n_sat) - 32'd1));
    total    = CountW'(pend_cnt_q) + n_sat;
    excess   = total - CountW'(16);
    word_sh  = acc >> excess;
    // Left-align the pending bits in 16 bits and fill the rest with ones.
    fl_shift = CountW'(16) - CountW'(pend_cnt_q);
    flush_al = ({17'd0, pend_q} << fl_shift) | ((32'd1 << fl_shift) - 32'd1);

    raw[0]   = '0;
    raw[1]   = '0;
    raw_cnt  = 2'd0;
    app_pend = pend_q;
    app_cnt  = pend_cnt_q;

    if (kind == KIND_APPEND) begin
      if (total >= CountW'(16)) begin
        raw[0]   = word_sh[15:8];
        raw[1]   = word_sh[7:0];
        raw_cnt  = 2'd2;
        app_cnt  = excess[PendCntW-1:0];
        app_pend = acc[PendW-1:0] & ((PendW'(1) << excess) - PendW'(1));
      end else begin
        app_cnt  = total[PendCntW-1:0];
        app_pend = acc[PendW-1:0];
      end
    end else begin
      raw[0] = flush_al[15:8];
      raw[1] = flush_al[7:0];
      if (pend_cnt_q == '0) begin
        raw_cnt = 2'd0;
      end else if (pend_cnt_q <= PendCntW'(8)) begin
        raw_cnt = 2'd1;
      end else begin
        raw_cnt = 2'd2;
      end
      app_cnt  = '0;
      app_pend = '0;
    end
  end

  // Stuffing: follow each 0xFF with a zero byte.
  byte_t      stuffed [MaxBytes];
  logic [2:0] st_cnt;

  always_comb begin
    for (int j = 0; j < MaxBytes; j++) begin
      stuffed[j] = StuffByte;
    end
    st_cnt = 3'd0;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < raw_cnt) begin
        stuffed[st_cnt[1:0]] = raw[i];
        st_cnt = st_cnt + 3'd1;
        if (raw[i] == MarkerByte) begin
          stuffed[st_cnt[1:0]] = StuffByte;
          st_cnt = st_cnt + 3'd1;
        end
      end
    end
  end

  // Next-state selection
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    buf_d      = buf_q;
    left_d     = left_q;
    rd_d       = rd_q;
    if (out_beat) begin
      left_d = left_q - 3'd1;
      rd_d   = rd_q + 2'd1;
    end
    if (in_beat) begin
      pend_d     = app_pend;
      pend_cnt_d = app_cnt;
      buf_d      = stuffed;
      left_d     = st_cnt;
      rd_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      pend_cnt_q <= '0;
      left_q     <= '0;
      rd_q       <= '0;
    end else begin
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
      left_q     <= left_d;
      rd_q       <= rd_d;
    end
  end

  // Hold the result bytes; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule
